/* sv/cfpf_pkg.sv */
// Shared types, codes and sizes for the contiguous free page finder.
package cfpf_pkg;

   // Default sizes handed to the top level parameters.
   localparam int NUM_PAGES_DEF  = 1024;
   localparam int PAGE_SHIFT_DEF = 12;

   // Internal page position width: holds a hint page plus a full page count.
   localparam int POS_W = 22;

   // Bitmap word width and its bit index width.
   localparam int WORD_W = 32;
   localparam int BIT_W  = 5;

   // Field widths of the item and result transfers.
   localparam int OP_W     = 2;
   localparam int COUNT_W  = 11;
   localparam int HINT_W   = 22;
   localparam int START_W  = 11;
   localparam int INDEX_W  = 10;
   localparam int STATUS_W = 2;
   localparam int PAGE_W   = 10;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 16;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_SEARCH    = 2'd0;
   localparam logic [OP_W-1:0] OP_MARK_USED = 2'd1;
   localparam logic [OP_W-1:0] OP_MARK_FREE = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE      = 2'd3;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_FOUND      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOSPACE    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISALIGNED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_MARKED     = 2'd3;

   // How an accepted item is handled.
   typedef enum logic [1:0] {
      CLS_IMMEDIATE,
      CLS_MARK,
      CLS_SEARCH
   } cls_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic clear_step;
      logic mark_read;
      logic mark_write;
      logic check;
      logic eval;
      logic load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      cls_type item_class;
      logic    clear_last;
      logic    chk_stop;
      logic    eval_stop;
      logic    eval_jump;
   } sts_type;

endpackage

/* sv/cfpf_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module cfpf_ram
   import cfpf_pkg::*;
#(
   parameter int WIDTH = WORD_W,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/cfpf_datapath.sv */
// Datapath: item registers, bitmap memory, run check and word scan, result registers.
module cfpf_datapath
   import cfpf_pkg::*;
#(
   parameter int NUM_PAGES  = NUM_PAGES_DEF,
   parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [OP_W-1:0]       req_tuser,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [STATUS_W-1:0]   rsp_tuser,
   input  cmd_type               cmd,
   output sts_type               sts
);

   localparam int WORDS = (NUM_PAGES + WORD_W - 1) / WORD_W;
   localparam int WI    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam logic [POS_W-1:0] NUM_PAGES_POS = POS_W'(NUM_PAGES);
   localparam logic [HINT_W-1:0] HINT_MASK = (HINT_W'(1) << PAGE_SHIFT) - HINT_W'(1);

   // Request fields.
   logic [OP_W-1:0]    req_op;
   logic [COUNT_W-1:0] req_count;
   logic [HINT_W-1:0]  req_hint;
   logic               req_mand;
   logic [START_W-1:0] req_start;
   logic [INDEX_W-1:0] req_index;

   assign req_op    = req_tuser;
   assign req_count = req_tdata[10:0];
   assign req_hint  = req_tdata[32:11];
   assign req_mand  = req_tdata[33];
   assign req_start = req_tdata[44:34];
   assign req_index = req_tdata[54:45];

   // Registers.
   logic [OP_W-1:0]     op_ff, op_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [INDEX_W-1:0]  index_ff, index_in;
   logic                mand_ff, mand_in;
   logic [POS_W-1:0]    base_ff, base_in;
   logic [POS_W-1:0]    probe_ff, probe_in;
   logic [POS_W-1:0]    target_ff, target_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [PAGE_W-1:0]   res_page_ff, res_page_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic [PAGE_W-1:0]   out_page_ff, out_page_in;
   logic [WI-1:0]       clr_addr_ff, clr_addr_in;

   // Memory port signals.
   logic              ram_wr_en;
   logic [WI-1:0]     ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;
   logic [WI-1:0]     ram_rd_addr;
   logic [WORD_W-1:0] ram_rd_data;

   // Decode of the item offered on the request channel.
   logic [POS_W-1:0] hint_page;
   logic [POS_W-1:0] start_pos;
   logic [POS_W-1:0] index_pos;
   logic             misaligned;
   logic             index_ok;
   logic [POS_W-1:0] first_base;
   cls_type          req_class;
   logic [STATUS_W-1:0] imm_status;

   assign hint_page  = POS_W'(req_hint >> PAGE_SHIFT);
   assign start_pos  = POS_W'(req_start);
   assign index_pos  = POS_W'(req_index);
   assign misaligned = |(req_hint & HINT_MASK);
   assign index_ok   = index_pos < NUM_PAGES_POS;
   assign first_base = (req_mand || (hint_page > start_pos)) ? hint_page : start_pos;

   always_comb begin
      req_class  = CLS_IMMEDIATE;
      imm_status = ST_MARKED;
      unique case (req_op) inside
         OP_SEARCH: begin
            if (req_mand && misaligned) begin
               imm_status = ST_MISALIGNED;
            end else begin
               req_class = CLS_SEARCH;
            end
         end
         OP_MARK_USED, OP_MARK_FREE: begin
            if (index_ok) begin
               req_class = CLS_MARK;
            end
         end
         default: begin
            req_class = CLS_IMMEDIATE;
         end
      endcase
   end

   // Run end check: target of the candidate run against the table end.
   logic [POS_W-1:0] check_target;
   logic             check_over;
   logic             check_zero;

   assign check_target = base_ff + POS_W'(count_ff);
   assign check_over   = check_target > NUM_PAGES_POS;
   assign check_zero   = count_ff == '0;

   // Word scan: look for a used entry in [probe, min(target, word end)).
   function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] bits);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (bits[i]) begin
            pos = BIT_W'(i);
         end
      end
      return pos;
   endfunction

   logic              same_word;
   logic [POS_W-1:0]  word_end;
   logic [POS_W-1:0]  seg_end;
   logic [BIT_W:0]    end_bit;
   logic [WORD_W:0]   low_mask;
   logic [WORD_W:0]   high_mask;
   logic [WORD_W:0]   wide_mask;
   logic [WORD_W-1:0] hits;
   logic              eval_hit;
   logic              eval_done;
   logic [POS_W-1:0]  used_pos;

   assign same_word = target_ff[POS_W-1:BIT_W] == probe_ff[POS_W-1:BIT_W];
   assign word_end  = (probe_ff | POS_W'(WORD_W - 1)) + POS_W'(1);
   assign seg_end   = same_word ? target_ff : word_end;
   assign end_bit   = same_word ? {1'b0, target_ff[BIT_W-1:0]} : (BIT_W + 1)'(WORD_W);
   assign low_mask  = ~(((WORD_W + 1)'(1) << probe_ff[BIT_W-1:0]) - (WORD_W + 1)'(1));
   assign high_mask = ((WORD_W + 1)'(1) << end_bit) - (WORD_W + 1)'(1);
   assign wide_mask = low_mask & high_mask;
   assign hits      = ram_rd_data & wide_mask[WORD_W-1:0];
   assign eval_hit  = |hits;
   assign eval_done = !eval_hit && (seg_end == target_ff);
   assign used_pos  = {probe_ff[POS_W-1:BIT_W], first_set(hits)};

   // Mark update of one bitmap word.
   logic [WORD_W-1:0] bit_mask;
   assign bit_mask = WORD_W'(1) << index_ff[BIT_W-1:0];

   // Memory address and data selection.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = clr_addr_ff;
      ram_wr_data = '0;
      ram_rd_addr = index_pos[WI+BIT_W-1:BIT_W];
      if (cmd.clear_step) begin
         ram_wr_en = 1'b1;
      end else if (cmd.mark_write) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = WI'(POS_W'(index_ff) >> BIT_W);
         ram_wr_data = (op_ff == OP_MARK_USED) ? (ram_rd_data | bit_mask)
                                               : (ram_rd_data & ~bit_mask);
      end
      if (cmd.mark_read) begin
         ram_rd_addr = WI'(POS_W'(index_ff) >> BIT_W);
      end else if (cmd.check) begin
         ram_rd_addr = base_ff[WI+BIT_W-1:BIT_W];
      end else if (cmd.eval) begin
         ram_rd_addr = seg_end[WI+BIT_W-1:BIT_W];
      end
   end

   // Next values of the datapath registers.
   always_comb begin
      op_in         = op_ff;
      count_in      = count_ff;
      index_in      = index_ff;
      mand_in       = mand_ff;
      base_in       = base_ff;
      probe_in      = probe_ff;
      target_in     = target_ff;
      res_status_in = res_status_ff;
      res_page_in   = res_page_ff;
      out_status_in = out_status_ff;
      out_page_in   = out_page_ff;
      clr_addr_in   = clr_addr_ff;
      if (cmd.clear_step) begin
         clr_addr_in = clr_addr_ff + WI'(1);
      end
      if (cmd.accept) begin
         op_in         = req_op;
         count_in      = req_count;
         index_in      = req_index;
         mand_in       = req_mand;
         base_in       = first_base;
         res_status_in = imm_status;
         res_page_in   = '0;
      end
      if (cmd.mark_write) begin
         res_status_in = ST_MARKED;
         res_page_in   = '0;
      end
      if (cmd.check) begin
         target_in = check_target;
         probe_in  = base_ff;
         if (check_over) begin
            res_status_in = ST_NOSPACE;
            res_page_in   = '0;
         end else begin
            res_status_in = ST_FOUND;
            res_page_in   = base_ff[PAGE_W-1:0];
         end
      end
      if (cmd.eval) begin
         probe_in = seg_end;
         if (eval_hit) begin
            base_in       = used_pos + POS_W'(1);
            res_status_in = ST_NOSPACE;
            res_page_in   = '0;
         end else begin
            res_status_in = ST_FOUND;
            res_page_in   = base_ff[PAGE_W-1:0];
         end
      end
      if (cmd.load_out) begin
         out_status_in = res_status_ff;
         out_page_in   = res_page_ff;
      end
   end

   // Clear counter is control state; the rest is payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      count_ff      <= count_in;
      index_ff      <= index_in;
      mand_ff       <= mand_in;
      base_ff       <= base_in;
      probe_ff      <= probe_in;
      target_ff     <= target_in;
      res_status_ff <= res_status_in;
      res_page_ff   <= res_page_in;
      out_status_ff <= out_status_in;
      out_page_ff   <= out_page_in;
   end

   // Used-entry bitmap, one word of entries per row.
   cfpf_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Status toward the controller.
   always_comb begin
      sts.item_class = req_class;
      sts.clear_last = clr_addr_ff == WI'(WORDS - 1);
      sts.chk_stop   = check_over || check_zero;
      sts.eval_stop  = eval_done || (eval_hit && mand_ff);
      sts.eval_jump  = eval_hit && !mand_ff;
   end

   assign rsp_tdata = {(RSP_DATA_W - PAGE_W)'(0), out_page_ff};
   assign rsp_tuser = out_status_ff;

   // A scanned word always lies strictly before the run target.
   a_probe_before_target: assert property (@(posedge clock) disable iff (reset)
      cmd.eval |-> (probe_ff < target_ff))
      else $error("scan probe reached the run target");

   // A run that passed the end check never reaches past the table end.
   a_target_in_table: assert property (@(posedge clock) disable iff (reset)
      (cmd.check && !check_over) |=> (target_ff <= NUM_PAGES_POS))
      else $error("run target beyond the table end");

   // A free segment never moves the probe past the target.
   a_free_step_bounded: assert property (@(posedge clock) disable iff (reset)
      (cmd.eval && !eval_hit) |=> (probe_ff <= target_ff))
      else $error("free segment stepped past the run target");

endmodule

/* sv/cfpf_ctrl.sv */
// Controller: clearing pass, item sequencing and result register handshake.
module cfpf_ctrl
   import cfpf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MARK_RD,
      S_MARK_WR,
      S_CHECK,
      S_EVAL,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               unique case (sts.item_class)
                  CLS_MARK:   state_in = S_MARK_RD;
                  CLS_SEARCH: state_in = S_CHECK;
                  default:    state_in = S_RESP;
               endcase
            end
         end
         S_MARK_RD: begin
            cmd.mark_read = 1'b1;
            state_in      = S_MARK_WR;
         end
         S_MARK_WR: begin
            cmd.mark_write = 1'b1;
            state_in       = S_RESP;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = sts.chk_stop ? S_RESP : S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (sts.eval_stop) begin
               state_in = S_RESP;
            end else if (sts.eval_jump) begin
               state_in = S_CHECK;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // Result register valid: set on load, cleared when the transfer completes.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // A new result is loaded only into a free or draining result register.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten while waiting");

endmodule

/* sv/contiguous_free_page_finder.sv */
// Top level of the contiguous free page finder: controller plus datapath.
//
// Keeps one used bit per page entry in a memory of 32-entry words and answers
// mark and first-fit search items with one result each. After reset a clearing
// pass writes the bitmap to all free, one word per cycle; no item is accepted
// during it. A mark item goes through accept, read, modify and write, and
// result load before the next item is accepted; an item that needs no table
// access goes through accept and result load. A search goes through accept,
// end check and result load, plus one scan step per 32-entry bitmap word the
// scan reads, plus one end check for each used entry the scan jumps past, after
// which the word holding the new start is read again; the bitmap memory has a
// single read port, read once per cycle. One item is in work at a time;
// the next item is accepted while a finished result still waits in the
// output register.
module contiguous_free_page_finder
   import cfpf_pkg::*;
#(
   parameter int NUM_PAGES  = NUM_PAGES_DEF,
   parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // page_count[10:0], hint_addr[32:11], hint_mandatory[33], search_start[44:34],
   // entry_index[54:45], zero fill[55]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // op[1:0]
   input  logic [OP_W-1:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // first_page[9:0], zero fill[15:10]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status[1:0]
   output logic [STATUS_W-1:0]   rsp_tuser
);

   cmd_type cmd;
   sts_type sts;

   cfpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   cfpf_datapath #(
      .NUM_PAGES  (NUM_PAGES),
      .PAGE_SHIFT (PAGE_SHIFT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule
